@@ hw/rtl/weekly_time_window_matcher_macros.svh @@
// Assertion macros used by the weekly time window matcher RTL.
`ifndef WEEKLY_TIME_WINDOW_MATCHER_MACROS_SVH
`define WEEKLY_TIME_WINDOW_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/wtw_pkg.sv @@
// Types, constants and helper functions for the weekly time window matcher.
`default_nettype none

package wtw_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_WD_WAIT,
    ST_CK_SCAN,
    ST_FIN_RD,
    ST_FIN_CALC,
    ST_DONE
  } state_e;

  // One stored window, 27 bits.
  typedef struct packed {
    logic [2:0] wday;
    logic [4:0] sh;
    logic [5:0] sm;
    logic [4:0] eh;
    logic [5:0] em;
    logic       rec;
    logic       str;
  } win_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned OUT_SEC_W = 17;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [11:0] MIN_PER_DAY   = 12'd1440;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;

  // Weekday arithmetic: year bias of 400 years keeps the year positive.
  localparam logic [12:0] YEAR_BIAS       = 13'd400;
  localparam logic [12:0] RECIP_100       = 13'd5243;  // ceil(2^19 / 100)
  localparam int unsigned RECIP_100_SHIFT = 19;
  localparam logic [13:0] RECIP_7         = 14'd9363;  // ceil(2^16 / 7)
  localparam int unsigned RECIP_7_SHIFT   = 16;

  function automatic logic [2:0] month_offset(input logic [3:0] mi);
    logic [2:0] off;
    case (mi)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // h*60 + m; fits 12 bits for any 5-bit hour and 6-bit minute.
  function automatic logic [11:0] minutes(input logic [4:0] h, input logic [5:0] m);
    logic [11:0] hx;
    hx = {7'd0, h};
    return (hx << 6) - (hx << 2) + {6'd0, m};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wtw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module wtw_ram #(
  parameter int unsigned Width = 27,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/wtw_weekday.sv @@
// Five-stage pipeline that turns a Gregorian date into a weekday, 1=Monday..7=Sunday.
`default_nettype none

module wtw_weekday (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  wtw_pkg::date_t date_i,
  output logic          done_o,
  output logic [2:0]    weekday_o
);
  import wtw_pkg::*;

  logic [4:0]  vld_q;

  logic [12:0] yy0;
  logic [3:0]  mi0;

  logic [12:0] yy1_q, yy2_q;
  logic [2:0]  off1_q, off2_q;
  logic [4:0]  day1_q, day2_q;
  logic [25:0] prod100;
  logic [6:0]  q100_q;
  logic [12:0] sum_d, sum3_q, sum4_q;
  logic [26:0] prod7;
  logic [10:0] q7_q;
  logic [12:0] r_full;
  logic [2:0]  wd_d, wd_q;

  // Month normalisation: month 0 is December of the year before, 13..15 roll over.
  always_comb begin
    yy0 = {1'b0, date_i.year} + YEAR_BIAS;
    mi0 = date_i.month;
    if (date_i.month == 4'd0) begin
      mi0 = 4'd12;
      yy0 = yy0 - 13'd1;
    end else if (date_i.month > 4'd12) begin
      mi0 = date_i.month - 4'd12;
      yy0 = yy0 + 13'd1;
    end
    if (mi0 < 4'd3) begin
      yy0 = yy0 - 13'd1;
    end
  end

  assign prod100 = 26'(yy1_q) * 26'(RECIP_100);

  always_comb begin
    sum_d = yy2_q + (yy2_q >> 2) - {6'd0, q100_q} + {8'd0, q100_q[6:2]}
            + {10'd0, off2_q} + {8'd0, day2_q};
  end

  assign prod7  = 27'(sum3_q) * 27'(RECIP_7);
  assign r_full = sum4_q - (({2'd0, q7_q} << 3) - {2'd0, q7_q});
  assign wd_d   = (r_full[2:0] == 3'd0) ? 3'd7 : r_full[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    yy1_q  <= yy0;
    off1_q <= month_offset(mi0);
    day1_q <= date_i.day;

    q100_q <= prod100[RECIP_100_SHIFT +: 7];
    yy2_q  <= yy1_q;
    off2_q <= off1_q;
    day2_q <= day1_q;

    sum3_q <= sum_d;

    q7_q   <= prod7[RECIP_7_SHIFT +: 11];
    sum4_q <= sum3_q;

    wd_q   <= wd_d;
  end

  assign done_o    = vld_q[4];
  assign weekday_o = wd_q;

endmodule

`default_nettype wire

@@ hw/rtl/weekly_time_window_matcher.sv @@
// Top level: weekly window store with add, remove, current-time check and no-op.
//
//  channel | valid      | stall       | beat fields
//  --------+------------+-------------+----------------------------------------------
//  in      | in_valid_i | in_stall_o  | op, window fields, calendar date, time now
//  out     | out_valid_o| out_stall_i | accepted, latch, window_seconds, weekday, count
//
// One beat is worked on at a time; every beat gives one result beat.
// Remove and check read the stored entries one at a time, as the window RAM
// has one read port, and a check first waits for the weekday pipeline. Reset
// clears the count and latch; the RAM contents need no clearing. A stalled
// result does not block acceptance of the next beat; its own result then
// waits in the final state.
`default_nettype none

module weekly_time_window_matcher #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  sched_weekday_i,
  input  logic [4:0]  start_hour_i,
  input  logic [5:0]  start_minute_i,
  input  logic [4:0]  end_hour_i,
  input  logic [5:0]  end_minute_i,
  input  logic [1:0]  action_flags_i,
  input  logic [11:0] cal_year_i,
  input  logic [3:0]  cal_month_i,
  input  logic [4:0]  cal_day_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        record_on_o,
  output logic        stream_on_o,
  output logic [4:0]  active_index_o,
  output logic [16:0] window_seconds_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  entry_count_o
);
  import wtw_pkg::*;

`include "weekly_time_window_matcher_macros.svh"

  localparam int unsigned LW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [LW-1:0] N_L = LW'(TABLE_ENTRIES);

  state_e state_q, state_d;

  op_e        op_q, op_d;
  logic [2:0] swd_q, swd_d;
  logic [4:0] sh_q, sh_d, eh_q, eh_d, nh_q, nh_d;
  logic [5:0] sm_q, sm_d, em_q, em_d, nm_q, nm_d;
  logic [1:0] flags_q, flags_d;

  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] lidx_q, lidx_d;
  logic          lrec_q, lrec_d, lstr_q, lstr_d;
  logic [2:0]    lwd_q, lwd_d;
  logic          ok_q, ok_d;
  logic [LW-1:0] ptr_q, ptr_d, idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [OUT_SEC_W-1:0] sec_q, sec_d;

  logic                 out_valid_q, out_valid_d;
  logic                 o_acc_q, o_acc_d, o_rec_q, o_rec_d, o_str_q, o_str_d;
  logic [OUT_IDX_W-1:0] o_idx_q, o_idx_d;
  logic [OUT_SEC_W-1:0] o_sec_q, o_sec_d;
  logic [2:0]           o_wd_q, o_wd_d;
  logic [OUT_CNT_W-1:0] o_cnt_q, o_cnt_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  win_t          ram_wdata, ram_rdata;

  logic       wd_start, wd_done;
  logic [2:0] wd_val;
  date_t      date_in;

  logic          accept, out_free, issue, scan_end;
  logic          rm_hit, ck_hit, add_ok, fin_in;
  logic [11:0]   st_m, en_m, en_x, cur_m, cur_x, dur_m;
  logic          wrap;
  logic [LW-1:0] shift_src;
  logic [OUT_SEC_W-1:0] sec_calc;
  logic [LW+OUT_IDX_W-1:0] lidx_ext;
  logic [LW+OUT_CNT_W-1:0] cnt_ext;

  wtw_ram #(
    .Width($bits(win_t)),
    .Depth(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign date_in = '{year: cal_year_i, month: cal_month_i, day: cal_day_i};

  wtw_weekday u_weekday (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wd_start),
    .date_i   (date_in),
    .done_o   (wd_done),
    .weekday_o(wd_val)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign wd_start   = accept && (op_e'(op_i) == OP_CHECK);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign issue    = (ptr_q < cnt_q);
  assign scan_end = !issue && !pend_q;

  assign add_ok = (cnt_q < N_L) && (swd_q != 3'd0)
                  && (sh_q < HOURS_PER_DAY) && (eh_q < HOURS_PER_DAY)
                  && (sm_q < MIN_PER_HOUR) && (em_q < MIN_PER_HOUR);

  assign rm_hit = pend_q && (ram_rdata.wday == swd_q) && (ram_rdata.sh == sh_q)
                  && (ram_rdata.sm == sm_q);

  // Window timing on the entry just read; overnight windows move the end a day on.
  always_comb begin
    st_m  = minutes(ram_rdata.sh, ram_rdata.sm);
    en_m  = minutes(ram_rdata.eh, ram_rdata.em);
    cur_m = minutes(nh_q, nm_q);
    wrap  = (en_m < st_m);
    en_x  = wrap ? (en_m + MIN_PER_DAY) : en_m;
    cur_x = (wrap && (cur_m < st_m)) ? (cur_m + MIN_PER_DAY) : cur_m;
    dur_m = en_x - st_m;
  end

  assign ck_hit = pend_q && (ram_rdata.wday == lwd_q) && (cur_x >= st_m) && (cur_x < en_x);

  assign fin_in   = (lidx_q < cnt_q);
  assign sec_calc = fin_in ? ((OUT_SEC_W'(dur_m) << 6) - (OUT_SEC_W'(dur_m) << 2)) : '0;

  // Shift writes land one slot below the entry whose data the RAM has just returned.
  assign shift_src = idx_q - LW'(1);

  assign lidx_ext = {{OUT_IDX_W{1'b0}}, lidx_q};
  assign cnt_ext  = {{OUT_CNT_W{1'b0}}, cnt_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_ADD:    state_d = ST_ADD;
            OP_REMOVE: state_d = ST_RM_SCAN;
            OP_CHECK:  state_d = ST_WD_WAIT;
            OP_NOP:    state_d = ST_FIN_RD;
          endcase
        end
      end
      ST_ADD:      state_d = ST_FIN_RD;
      ST_RM_SCAN: begin
        if (rm_hit) begin
          state_d = ST_RM_SHIFT;
        end else if (scan_end) begin
          state_d = ST_FIN_RD;
        end
      end
      ST_RM_SHIFT: begin
        if (scan_end) begin
          state_d = ST_FIN_RD;
        end
      end
      ST_WD_WAIT: begin
        if (wd_done) begin
          state_d = ST_CK_SCAN;
        end
      end
      ST_CK_SCAN: begin
        if (ck_hit || scan_end) begin
          state_d = ST_FIN_RD;
        end
      end
      ST_FIN_RD:   state_d = ST_FIN_CALC;
      ST_FIN_CALC: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d    = op_q;
    swd_d   = swd_q;
    sh_d    = sh_q;
    sm_d    = sm_q;
    eh_d    = eh_q;
    em_d    = em_q;
    flags_d = flags_q;
    nh_d    = nh_q;
    nm_d    = nm_q;
    cnt_d   = cnt_q;
    lidx_d  = lidx_q;
    lrec_d  = lrec_q;
    lstr_d  = lstr_q;
    lwd_d   = lwd_q;
    ok_d    = ok_q;
    ptr_d   = ptr_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    sec_d   = sec_q;

    out_valid_d = out_valid_q && out_stall_i;
    o_acc_d     = o_acc_q;
    o_rec_d     = o_rec_q;
    o_str_d     = o_str_q;
    o_idx_d     = o_idx_q;
    o_sec_d     = o_sec_q;
    o_wd_d      = o_wd_q;
    o_cnt_d     = o_cnt_q;

    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_raddr = ptr_q[AW-1:0];
    ram_wdata = '{wday: swd_q, sh: sh_q, sm: sm_q, eh: eh_q, em: em_q,
                  rec: flags_q[0], str: flags_q[1]};

    unique case (state_q)
      ST_IDLE: begin
        ptr_d  = '0;
        pend_d = 1'b0;
        if (accept) begin
          op_d    = op_e'(op_i);
          swd_d   = sched_weekday_i;
          sh_d    = start_hour_i;
          sm_d    = start_minute_i;
          eh_d    = end_hour_i;
          em_d    = end_minute_i;
          flags_d = action_flags_i;
          nh_d    = now_hour_i;
          nm_d    = now_minute_i;
          ok_d    = 1'b0;
        end
      end
      ST_ADD: begin
        if (add_ok) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + LW'(1);
          ok_d   = 1'b1;
        end
      end
      ST_RM_SCAN: begin
        ptr_d  = issue ? (ptr_q + LW'(1)) : ptr_q;
        pend_d = issue;
        idx_d  = ptr_q;
        if (rm_hit) begin
          ptr_d  = idx_q + LW'(1);
          pend_d = 1'b0;
          ok_d   = 1'b1;
        end
      end
      ST_RM_SHIFT: begin
        ptr_d  = issue ? (ptr_q + LW'(1)) : ptr_q;
        pend_d = issue;
        idx_d  = ptr_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = shift_src[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (scan_end) begin
          cnt_d = cnt_q - LW'(1);
        end
      end
      ST_WD_WAIT: begin
        ok_d = 1'b1;
        if (wd_done) begin
          lwd_d = wd_val;
        end
      end
      ST_CK_SCAN: begin
        ptr_d  = issue ? (ptr_q + LW'(1)) : ptr_q;
        pend_d = issue;
        idx_d  = ptr_q;
        if (ck_hit) begin
          lrec_d = ram_rdata.rec;
          lstr_d = ram_rdata.str;
          lidx_d = idx_q;
        end else if (scan_end) begin
          lrec_d = 1'b0;
          lstr_d = 1'b0;
          lidx_d = N_L;
        end
      end
      ST_FIN_RD: begin
        ram_raddr = lidx_q[AW-1:0];
      end
      ST_FIN_CALC: begin
        sec_d = sec_calc;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_acc_d     = ok_q;
          o_rec_d     = lrec_q;
          o_str_d     = lstr_q;
          o_idx_d     = lidx_ext[OUT_IDX_W-1:0];
          o_sec_d     = sec_q;
          o_wd_d      = lwd_q;
          o_cnt_d     = cnt_ext[OUT_CNT_W-1:0];
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lidx_q      <= N_L;
      lrec_q      <= 1'b0;
      lstr_q      <= 1'b0;
      lwd_q       <= 3'd1;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lidx_q      <= lidx_d;
      lrec_q      <= lrec_d;
      lstr_q      <= lstr_d;
      lwd_q       <= lwd_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    swd_q   <= swd_d;
    sh_q    <= sh_d;
    sm_q    <= sm_d;
    eh_q    <= eh_d;
    em_q    <= em_d;
    flags_q <= flags_d;
    nh_q    <= nh_d;
    nm_q    <= nm_d;
    ok_q    <= ok_d;
    idx_q   <= idx_d;
    sec_q   <= sec_d;
    o_acc_q <= o_acc_d;
    o_rec_q <= o_rec_d;
    o_str_q <= o_str_d;
    o_idx_q <= o_idx_d;
    o_sec_q <= o_sec_d;
    o_wd_q  <= o_wd_d;
    o_cnt_q <= o_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = o_acc_q;
  assign record_on_o      = o_rec_q;
  assign stream_on_o      = o_str_q;
  assign active_index_o   = o_idx_q;
  assign window_seconds_o = o_sec_q;
  assign weekday_o        = o_wd_q;
  assign entry_count_o    = o_cnt_q;

  // op_q is kept for debug visibility of the beat in flight.
  logic op_is_add;
  assign op_is_add = (op_q == OP_ADD);

  `WTW_ASSERT_NOW(a_count_bound, 1'b1, (cnt_q <= N_L) && (lidx_q <= N_L),
    "window count or latched index beyond table size")
  `WTW_ASSERT_NEXT(a_add_grows, (state_q == ST_ADD) && add_ok && op_is_add,
    cnt_q == $past(cnt_q) + LW'(1), "stored add did not bump the count")
  `WTW_ASSERT_NOW(a_shift_ports, (state_q == ST_RM_SHIFT) && ram_we,
    ram_waddr != ram_raddr, "shift write collides with shift read")

endmodule

`default_nettype wire
